// File: rtl/lpf_pkg.sv
// Shared types, codes and helper functions of the longest-prefix forwarder.
// Used by lpf_cell and ipv4_longest_prefix_forwarder_unit; no dependencies.
`default_nettype none

package lpf_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int ADDR_W          = 32;
  localparam int LEN_W           = 6;
  localparam int TTL_W           = 8;
  localparam int PROTO_W         = 8;
  localparam int CSUM_W          = 16;
  localparam int MODE_W          = 2;
  localparam int VERDICT_W       = 2;
  localparam int IN_DATA_W       = 136;
  localparam int OUT_DATA_W      = 56;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

  typedef enum logic [MODE_W-1:0] {
    MODE_FWD   = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_CLEAR = 2'd2
  } lpf_mode_e;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_LOCAL   = 2'd0,
    VERDICT_FWD     = 2'd1,
    VERDICT_EXPIRED = 2'd2,
    VERDICT_NOROUTE = 2'd3
  } lpf_verdict_e;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] dest;
    logic              found;
    logic [LEN_W-1:0]  best_len;
    logic [ADDR_W-1:0] best_nh;
  } lpf_tok_t;

  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] nh;
  } lpf_wr_t;

  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] mask;
    mask = '0;
    if (len >= MAX_LEN) begin
      mask = '1;
    end else if (len != '0) begin
      mask = {ADDR_W{1'b1}} << (MAX_LEN - len);
    end
    return mask;
  endfunction

  function automatic logic [CSUM_W-1:0] csum_update(input logic [CSUM_W-1:0] hc,
                                                    input logic [CSUM_W-1:0] m_old,
                                                    input logic [CSUM_W-1:0] m_new);
    logic [CSUM_W+1:0] s0;
    logic [CSUM_W:0]   s1;
    logic [CSUM_W-1:0] s2;
    s0 = {2'b00, ~hc} + {2'b00, ~m_old} + {2'b00, m_new};
    s1 = {1'b0, s0[CSUM_W-1:0]} + {{(CSUM_W-1){1'b0}}, s0[CSUM_W+1:CSUM_W]};
    s2 = s1[CSUM_W-1:0] + {{(CSUM_W-1){1'b0}}, s1[CSUM_W]};
    return ~s2;
  endfunction

endpackage

`default_nettype wire

// File: rtl/lpf_cell.sv
// One route cell of the lookup row: holds one table entry and refines the
// passing lookup with it. Depends on lpf_pkg.
`default_nettype none

module lpf_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  lpf_pkg::lpf_wr_t wr_i,
  input  logic             entry_valid_i,
  input  lpf_pkg::lpf_tok_t tok_i,
  output lpf_pkg::lpf_tok_t tok_o
);
  import lpf_pkg::*;

  logic [ADDR_W-1:0] prefix_q;
  logic [LEN_W-1:0]  len_q;
  logic [ADDR_W-1:0] nh_q;
  logic [LEN_W-1:0]  len_sat;
  logic              valid_q;
  lpf_tok_t          tok_q;
  lpf_tok_t          tok_d;
  logic              hit;

  assign len_sat = (wr_i.len > MAX_LEN) ? MAX_LEN : wr_i.len;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      len_q    <= len_sat;
      prefix_q <= wr_i.prefix & prefix_mask(len_sat);
      nh_q     <= wr_i.nh;
    end
  end

  always_comb begin
    hit   = entry_valid_i && ((tok_i.dest & prefix_mask(len_q)) == prefix_q) &&
            (!tok_i.found || (len_q > tok_i.best_len));
    tok_d = tok_i;
    if (hit) begin
      tok_d.found    = 1'b1;
      tok_d.best_len = len_q;
      tok_d.best_nh  = nh_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = valid_q;
  end

endmodule

`default_nettype wire

// File: rtl/ipv4_longest_prefix_forwarder_unit.sv
// Top level of the IPv4 longest-prefix forwarder: request handshakes, control
// and the row of lpf_cell route cells. Depends on lpf_pkg and lpf_cell.
`default_nettype none

// Each request is a forward, an add-route or a clear-table command. Add,
// clear, and forwards that are delivered locally or dropped for TTL zero need
// no lookup. A forward that needs a route lookup travels through the row of
// TABLE_DEPTH route cells, one cell per cycle, and its verdict is registered
// from the last cell. A request is taken only while no lookup runs and the
// output register is empty or being read. The cell row is the only route
// storage; a clear only resets the entry count.
module ipv4_longest_prefix_forwarder_unit #(
  parameter int TABLE_DEPTH = lpf_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_wr_en_i,
  input  logic [lpf_pkg::ADDR_W-1:0]          cfg_wr_data_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // dest_addr, ttl_in, protocol_in, old_checksum, route_prefix_in,
  // route_length_in, next_hop_in, zero pad
  input  logic [lpf_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,
  // mode
  input  logic [lpf_pkg::MODE_W-1:0]          s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // next_hop, new_ttl, new_checksum
  output logic [lpf_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  // verdict
  output logic [lpf_pkg::VERDICT_W-1:0]       m_axis_tuser_o
);
  import lpf_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  count_q;
  logic [ADDR_W-1:0] local_q;
  logic              out_valid_q;
  logic              out_valid_d;
  lpf_verdict_e      out_verdict_q;
  logic [ADDR_W-1:0] out_nh_q;
  logic [TTL_W-1:0]  out_ttl_q;
  logic [CSUM_W-1:0] out_csum_q;
  logic [TTL_W-1:0]  ttl_q;
  logic [CSUM_W-1:0] csum_q;
  logic [TTL_W-1:0]  ttl_new_q;
  logic [CSUM_W-1:0] csum_new_q;

  logic              in_accept;
  logic              out_accept;
  lpf_mode_e         in_mode;
  logic [ADDR_W-1:0] in_dest;
  logic [TTL_W-1:0]  in_ttl;
  logic [PROTO_W-1:0] in_proto;
  logic [CSUM_W-1:0] in_csum;
  logic [TTL_W-1:0]  in_ttl_dec;
  lpf_wr_t           in_wr;
  logic              launch;

  lpf_tok_t          tok [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] tok_valid_vec;
  lpf_tok_t          tail;

  assign in_mode     = lpf_mode_e'(s_axis_tuser_i);
  assign in_dest     = s_axis_tdata_i[31:0];
  assign in_ttl      = s_axis_tdata_i[39:32];
  assign in_proto    = s_axis_tdata_i[47:40];
  assign in_csum     = s_axis_tdata_i[63:48];
  assign in_wr.prefix = s_axis_tdata_i[95:64];
  assign in_wr.len    = s_axis_tdata_i[101:96];
  assign in_wr.nh     = s_axis_tdata_i[133:102];
  assign in_ttl_dec  = in_ttl - TTL_W'(1);

  assign s_axis_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign in_accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_accept = out_valid_q && m_axis_tready_i;
  assign launch     = in_accept && (in_mode == MODE_FWD) && (in_dest != local_q) &&
                      (in_ttl != '0);

  always_comb begin
    tok[0].valid    = launch;
    tok[0].dest     = in_dest;
    tok[0].found    = 1'b0;
    tok[0].best_len = '0;
    tok[0].best_nh  = '0;
  end

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    logic wr_en;
    logic entry_valid;
    assign wr_en       = in_accept && (in_mode == MODE_ADD) && (count_q == CNT_W'(k));
    assign entry_valid = CNT_W'(k) < count_q;
    lpf_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .wr_en_i       (wr_en),
      .wr_i          (in_wr),
      .entry_valid_i (entry_valid),
      .tok_i         (tok[k]),
      .tok_o         (tok[k+1])
    );
    assign tok_valid_vec[k] = tok[k+1].valid;
  end

  assign tail = tok[TABLE_DEPTH];

  always_comb begin
    out_valid_d = out_valid_q && !out_accept;
    if (in_accept && (in_mode == MODE_FWD) && !launch) begin
      out_valid_d = 1'b1;
    end
    if ((state_q == ST_LOOKUP) && tail.valid) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_q <= '0;
    end else if (cfg_wr_en_i) begin
      local_q <= cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      count_q       <= '0;
      out_valid_q   <= 1'b0;
      out_verdict_q <= VERDICT_LOCAL;
      out_nh_q      <= '0;
      out_ttl_q     <= '0;
      out_csum_q    <= '0;
      ttl_q         <= '0;
      csum_q        <= '0;
      ttl_new_q     <= '0;
      csum_new_q    <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            case (in_mode)
              MODE_FWD: begin
                if (launch) begin
                  state_q <= ST_LOOKUP;
                end
              end
              MODE_ADD: begin
                if (count_q < CNT_W'(TABLE_DEPTH)) begin
                  count_q <= count_q + CNT_W'(1);
                end
              end
              MODE_CLEAR: begin
                count_q <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_LOOKUP: begin
          if (tail.valid) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (in_accept && (in_mode == MODE_FWD)) begin
        ttl_q      <= in_ttl;
        csum_q     <= in_csum;
        ttl_new_q  <= in_ttl_dec;
        csum_new_q <= csum_update(in_csum, {in_ttl, in_proto}, {in_ttl_dec, in_proto});
        out_nh_q   <= '0;
        out_ttl_q  <= in_ttl;
        out_csum_q <= in_csum;
        out_verdict_q <= (in_dest == local_q) ? VERDICT_LOCAL : VERDICT_EXPIRED;
      end else if ((state_q == ST_LOOKUP) && tail.valid) begin
        if (tail.found) begin
          out_verdict_q <= VERDICT_FWD;
          out_nh_q      <= tail.best_nh;
          out_ttl_q     <= ttl_new_q;
          out_csum_q    <= csum_new_q;
        end else begin
          out_verdict_q <= VERDICT_NOROUTE;
          out_nh_q      <= '0;
          out_ttl_q     <= ttl_q;
          out_csum_q    <= csum_q;
        end
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_csum_q, out_ttl_q, out_nh_q};
  assign m_axis_tuser_o  = out_verdict_q;

  a_lookup_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP) |-> !out_valid_q)
    else $error("result pending during lookup");

  a_tail_in_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid |-> (state_q == ST_LOOKUP))
    else $error("lookup left the cell row outside a lookup");

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_valid_vec))
    else $error("more than one lookup in the cell row");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

endmodule

`default_nettype wire
